/* sv/positional_list_store_core_assert.svh */
// Assertion macros for the positional list store core.
// Used by the top level only; no other dependencies.
`ifndef POSITIONAL_LIST_STORE_CORE_ASSERT_SVH
`define POSITIONAL_LIST_STORE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define PLST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("positional list store: assertion failed");
`define PLST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("positional list store: assertion failed");
`else
`define PLST_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PLST_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* sv/plst_pkg.sv */
// Shared types, codes and sizes of the positional list store.
// No dependencies; used by every module of the block.
package plst_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int POS_W = 8;
	localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
	localparam int ENTRY_W = 5;

	localparam logic [2:0] OP_INS_FRONT = 3'd0;
	localparam logic [2:0] OP_INS_POS   = 3'd1;
	localparam logic [2:0] OP_INS_END   = 3'd2;
	localparam logic [2:0] OP_DEL_FRONT = 3'd3;
	localparam logic [2:0] OP_DEL_POS   = 3'd4;
	localparam logic [2:0] OP_DEL_END   = 3'd5;
	localparam logic [2:0] OP_TRAVERSE  = 3'd6;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BELOW_ONE = 3'd1;
	localparam logic [2:0] ST_RANGE     = 3'd2;
	localparam logic [2:0] ST_EMPTY     = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;

	typedef enum logic [1:0] {
		KIND_INS,
		KIND_DEL,
		KIND_TRAV,
		KIND_NOP
	} kind_t;

	typedef struct packed {
		logic [2:0]         opcode;
		logic signed [31:0] value_in;
		logic [POS_W-1:0]   position;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] value_out;
		logic [ENTRY_W-1:0] entry_count;
		logic               last;
	} out_item_t;

	typedef struct packed {
		logic accept;
		logic shift_rd;
		logic trav_rd;
		logic fin;
		logic load_resp;
		logic load_trav;
	} dp_cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  err;
		logic  moves_zero;
		logic  rd_last;
		logic  count_zero;
		logic  full;
		logic  pend_v;
	} dp_sts_t;

endpackage

/* sv/plst_datapath.sv */
// Datapath of the positional list store: entry memory, count, shift and result registers.
// Depends on plst_pkg; driven by plst_controller through dp_cmd_t.
module plst_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  plst_pkg::dp_cmd_t   cmd,
	output plst_pkg::dp_sts_t   sts,
	input  plst_pkg::in_item_t  in_data,
	output plst_pkg::out_item_t res
);

	logic [31:0] mem [plst_pkg::CAPACITY];

	logic [plst_pkg::CNT_W-1:0] count_q;
	logic [2:0]                 op_q;
	logic [31:0]                value_q;
	logic [2:0]                 status_q;
	logic [plst_pkg::IDX_W-1:0] slot_q;
	logic [plst_pkg::IDX_W-1:0] idx_q;
	logic [plst_pkg::IDX_W-1:0] end_q;
	logic                       mz_q;
	logic                       pend_v_q;
	logic [plst_pkg::IDX_W-1:0] pend_addr_q;
	logic [31:0]                rd_q;
	plst_pkg::out_item_t        res_q;

	logic [plst_pkg::CMP_W-1:0] cnt_w;
	logic [plst_pkg::CMP_W-1:0] pos_w;
	logic [plst_pkg::IDX_W-1:0] n_idx;
	logic [plst_pkg::IDX_W-1:0] nm1_idx;
	logic [plst_pkg::IDX_W-1:0] pos_idx;
	logic [plst_pkg::IDX_W-1:0] pm1_idx;
	logic                       full;
	logic                       empty;
	logic [2:0]                 st_d;
	logic [plst_pkg::IDX_W-1:0] slot_d;
	logic [plst_pkg::IDX_W-1:0] start_d;
	logic [plst_pkg::IDX_W-1:0] end_d;
	logic                       mz_d;
	plst_pkg::kind_t            kind;
	logic                       is_ins;

	assign cnt_w   = plst_pkg::CMP_W'(count_q);
	assign pos_w   = plst_pkg::CMP_W'(in_data.position);
	assign n_idx   = plst_pkg::IDX_W'(count_q);
	assign nm1_idx = plst_pkg::IDX_W'(count_q - 1'b1);
	assign pos_idx = plst_pkg::IDX_W'(in_data.position);
	assign pm1_idx = plst_pkg::IDX_W'(in_data.position - 1'b1);
	assign full    = (count_q == plst_pkg::CNT_W'(plst_pkg::CAPACITY));
	assign empty   = (count_q == '0);

	always_comb begin
		st_d    = plst_pkg::ST_OK;
		slot_d  = '0;
		start_d = '0;
		end_d   = nm1_idx;
		mz_d    = 1'b1;
		case (in_data.opcode)
			plst_pkg::OP_INS_FRONT: begin
				if (full) st_d = plst_pkg::ST_FULL;
				start_d = nm1_idx;
				end_d   = '0;
				mz_d    = empty;
			end
			plst_pkg::OP_INS_POS: begin
				if (pos_w == '0) st_d = plst_pkg::ST_BELOW_ONE;
				else if (pos_w > cnt_w + 1'b1) st_d = plst_pkg::ST_RANGE;
				else if (full) st_d = plst_pkg::ST_FULL;
				slot_d  = pm1_idx;
				start_d = nm1_idx;
				end_d   = pm1_idx;
				mz_d    = (pos_w == cnt_w + 1'b1);
			end
			plst_pkg::OP_INS_END: begin
				if (full) st_d = plst_pkg::ST_FULL;
				slot_d = n_idx;
			end
			plst_pkg::OP_DEL_FRONT: begin
				if (empty) st_d = plst_pkg::ST_EMPTY;
				start_d = plst_pkg::IDX_W'(1);
				mz_d    = (count_q == plst_pkg::CNT_W'(1));
			end
			plst_pkg::OP_DEL_POS: begin
				if (empty) st_d = plst_pkg::ST_EMPTY;
				else if (pos_w == '0) st_d = plst_pkg::ST_BELOW_ONE;
				else if (pos_w > cnt_w) st_d = plst_pkg::ST_RANGE;
				slot_d  = pm1_idx;
				start_d = pos_idx;
				mz_d    = (pos_w == cnt_w);
			end
			plst_pkg::OP_DEL_END: begin
				if (empty) st_d = plst_pkg::ST_EMPTY;
			end
			plst_pkg::OP_TRAVERSE: begin
				if (empty) st_d = plst_pkg::ST_EMPTY;
			end
			default: begin
				st_d = plst_pkg::ST_OK;
			end
		endcase
	end

	always_comb begin
		case (op_q)
			plst_pkg::OP_INS_FRONT, plst_pkg::OP_INS_POS, plst_pkg::OP_INS_END:
				kind = plst_pkg::KIND_INS;
			plst_pkg::OP_DEL_FRONT, plst_pkg::OP_DEL_POS, plst_pkg::OP_DEL_END:
				kind = plst_pkg::KIND_DEL;
			plst_pkg::OP_TRAVERSE:
				kind = plst_pkg::KIND_TRAV;
			default:
				kind = plst_pkg::KIND_NOP;
		endcase
	end

	assign is_ins = (kind == plst_pkg::KIND_INS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			pend_v_q <= 1'b0;
		end else begin
			pend_v_q <= cmd.shift_rd;
			if (cmd.fin) begin
				if (is_ins) count_q <= count_q + 1'b1;
				else count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q     <= in_data.opcode;
			value_q  <= in_data.value_in;
			status_q <= st_d;
			slot_q   <= slot_d;
			idx_q    <= start_d;
			end_q    <= end_d;
			mz_q     <= mz_d;
		end else if (cmd.shift_rd) begin
			idx_q       <= is_ins ? idx_q - 1'b1 : idx_q + 1'b1;
			pend_addr_q <= is_ins ? idx_q + 1'b1 : idx_q - 1'b1;
		end else if (cmd.load_trav) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_v_q) begin
			mem[pend_addr_q] <= rd_q;
		end else if (cmd.fin && is_ins) begin
			mem[slot_q] <= value_q;
		end
		if (cmd.shift_rd || cmd.trav_rd) begin
			rd_q <= mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_resp) begin
			res_q.status      <= status_q;
			res_q.value_out   <= '0;
			res_q.entry_count <= plst_pkg::ENTRY_W'(count_q);
			res_q.last        <= 1'b1;
		end else if (cmd.load_trav) begin
			res_q.status      <= plst_pkg::ST_OK;
			res_q.value_out   <= rd_q;
			res_q.entry_count <= plst_pkg::ENTRY_W'(count_q);
			res_q.last        <= (idx_q == end_q);
		end
	end

	assign res = res_q;

	assign sts.kind       = kind;
	assign sts.err        = (status_q != plst_pkg::ST_OK);
	assign sts.moves_zero = mz_q;
	assign sts.rd_last    = (idx_q == end_q);
	assign sts.count_zero = empty;
	assign sts.full       = full;
	assign sts.pend_v     = pend_v_q;

endmodule

/* sv/plst_controller.sv */
// Controller of the positional list store: sequences shift, traverse and result loading.
// Depends on plst_pkg; steers plst_datapath through dp_cmd_t and owns the output valid.
module plst_controller (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output plst_pkg::dp_cmd_t cmd,
	input  plst_pkg::dp_sts_t sts
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISP,
		S_SHIFT,
		S_DRAIN,
		S_FIN,
		S_RESP,
		S_TRD,
		S_TOUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		cmd           = '0;
		cmd.accept    = (state_q == S_IDLE) && in_valid;
		cmd.shift_rd  = (state_q == S_SHIFT);
		cmd.trav_rd   = (state_q == S_TRD);
		cmd.fin       = (state_q == S_FIN);
		cmd.load_resp = (state_q == S_RESP) && out_free;
		cmd.load_trav = (state_q == S_TOUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_resp || cmd.load_trav) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_DISP;
				end
				S_DISP: begin
					if (sts.err || sts.kind == plst_pkg::KIND_NOP) state_q <= S_RESP;
					else if (sts.kind == plst_pkg::KIND_TRAV) state_q <= S_TRD;
					else if (sts.moves_zero) state_q <= S_FIN;
					else state_q <= S_SHIFT;
				end
				S_SHIFT: begin
					if (sts.rd_last) state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_free) state_q <= S_IDLE;
				end
				S_TRD: begin
					state_q <= S_TOUT;
				end
				S_TOUT: begin
					if (out_free) state_q <= sts.rd_last ? S_IDLE : S_TRD;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

/* sv/positional_list_store_core.sv */
// Positional list store: bounded ordered list of signed 32-bit values, up to CAPACITY entries.
// Input channel in_valid/in_ready carries one operation (in_item_t): insert front, insert at
// a 1-based position, insert end, delete front, delete at a position, delete end, traverse.
// Output channel out_valid/out_ready carries results (out_item_t): status, value_out,
// entry_count after the operation, and last on the final result of an operation.
// Every operation but traverse gives one status result; traverse gives one result per entry
// in list order, or a single empty result when the list holds nothing.
// One operation is in work at a time; in_ready is high only between operations.
// From acceptance the controller steps through a dispatch state, then: straight to the
// result load for a failed check or the unused opcode; through a finish state for an insert
// or delete that moves no entry; through shift, drain and finish states for one that moves
// entries (one registered read and one write a cycle on the entry memory). Traverse repeats
// a memory read, then a result load, once per entry.
// The next operation can be accepted in the cycle after the last result loads.
// The result register holds a result until taken; a stalled receiver holds the controller
// before the next result, and the next operation is accepted while the last result waits.
// Reset (arst_n low) empties the list and drops any pending result; the entry memory is
// not cleared, only entries below the count are ever read.
// Depends on plst_pkg, plst_datapath, plst_controller and the assertion macro header.
`include "positional_list_store_core_assert.svh"
module positional_list_store_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  plst_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output plst_pkg::out_item_t out_data
);

	plst_pkg::dp_cmd_t cmd;
	plst_pkg::dp_sts_t sts;

	plst_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	plst_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.in_data (in_data),
		.res     (out_data)
	);

	`PLST_ASSERT_IMP(a_one_cmd, clk, arst_n, 1'b1, $onehot0(cmd))
	`PLST_ASSERT_IMP(a_ins_not_full, clk, arst_n, cmd.fin && sts.kind == plst_pkg::KIND_INS, !sts.full)
	`PLST_ASSERT_IMP(a_trav_nonempty, clk, arst_n, cmd.load_trav, !sts.count_zero)
	`PLST_ASSERT_IMP(a_idle_no_write, clk, arst_n, in_ready, !sts.pend_v)
	`PLST_ASSERT_NEXT(a_resp_to_idle, clk, arst_n, cmd.load_resp, in_ready)

endmodule
